FILE: hw/rtl/grapheme_cluster_break_detector_top_assert.svh
// assertion macros for the grapheme cluster break detector
`ifndef GRAPHEME_CLUSTER_BREAK_DETECTOR_TOP_ASSERT_SVH
`define GRAPHEME_CLUSTER_BREAK_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GCBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcbd same-cycle check failed");

// next-cycle implication, checked outside reset
`define GCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcbd next-cycle check failed");

`endif

FILE: hw/rtl/gcbd_pkg.sv
// types and unit type codes for the grapheme cluster break detector
`default_nettype none

package gcbd_pkg;

    localparam int UNIT_W = 4;

    typedef logic [UNIT_W-1:0] unit_t;

    localparam unit_t TY_OTHER   = 4'd0;
    localparam unit_t TY_CR      = 4'd1;
    localparam unit_t TY_LF      = 4'd2;
    localparam unit_t TY_CONTROL = 4'd3;
    localparam unit_t TY_EXTEND  = 4'd4;
    localparam unit_t TY_ZWJ     = 4'd5;
    localparam unit_t TY_RI      = 4'd6;
    localparam unit_t TY_PREPEND = 4'd7;
    localparam unit_t TY_SPACING = 4'd8;
    localparam unit_t TY_L       = 4'd9;
    localparam unit_t TY_V       = 4'd10;
    localparam unit_t TY_T       = 4'd11;
    localparam unit_t TY_LV      = 4'd12;
    localparam unit_t TY_LVT     = 4'd13;
    localparam unit_t TY_EXTPICT = 4'd14;

    typedef struct packed {
        unit_t prev_type;
        logic  first_pending;
        logic  in_pict;
        logic  regional_odd;
    } gcbd_state_t;

    localparam gcbd_state_t STATE_RESET = '{
        prev_type:     TY_OTHER,
        first_pending: 1'b1,
        in_pict:       1'b0,
        regional_odd:  1'b0
    };

endpackage

`default_nettype wire

FILE: hw/rtl/gcbd_rules.sv
// break rule evaluation and context update for one unit
`default_nettype none

module gcbd_rules
    import gcbd_pkg::*;
(
    input  gcbd_state_t cur_state,
    input  unit_t       unit_type,
    input  logic        start_of_text,
    output logic        brk,
    output gcbd_state_t next_state
);

    gcbd_state_t eff;
    unit_t       lhs;
    logic        lhs_ctl;
    logic        rhs_ctl;

    assign eff     = start_of_text ? STATE_RESET : cur_state;
    assign lhs     = eff.prev_type;
    assign lhs_ctl = (lhs == TY_CR) || (lhs == TY_LF) || (lhs == TY_CONTROL);
    assign rhs_ctl = (unit_type == TY_CR) || (unit_type == TY_LF) ||
                     (unit_type == TY_CONTROL);

    always_comb
    begin
        if (eff.first_pending)
        begin
            brk = 1'b1;
        end
        else if (lhs == TY_CR && unit_type == TY_LF)
        begin
            brk = 1'b0;
        end
        else if (lhs_ctl || rhs_ctl)
        begin
            brk = 1'b1;
        end
        else if (lhs == TY_L && (unit_type == TY_L || unit_type == TY_V ||
                                 unit_type == TY_LV || unit_type == TY_LVT))
        begin
            brk = 1'b0;
        end
        else if ((lhs == TY_LV || lhs == TY_V) && (unit_type == TY_V || unit_type == TY_T))
        begin
            brk = 1'b0;
        end
        else if ((lhs == TY_LVT || lhs == TY_T) && unit_type == TY_T)
        begin
            brk = 1'b0;
        end
        else if (unit_type == TY_EXTEND || unit_type == TY_ZWJ ||
                 unit_type == TY_SPACING || lhs == TY_PREPEND)
        begin
            brk = 1'b0;
        end
        else if (eff.in_pict && lhs == TY_ZWJ && unit_type == TY_EXTPICT)
        begin
            brk = 1'b0;
        end
        else if (lhs == TY_RI && unit_type == TY_RI && eff.regional_odd)
        begin
            brk = 1'b0;
        end
        else
        begin
            brk = 1'b1;
        end
    end

    always_comb
    begin
        next_state.prev_type     = unit_type;
        next_state.first_pending = 1'b0;
        if (unit_type == TY_EXTPICT)
        begin
            next_state.in_pict = 1'b1;
        end
        else if (unit_type != TY_EXTEND && unit_type != TY_ZWJ)
        begin
            next_state.in_pict = 1'b0;
        end
        else
        begin
            next_state.in_pict = eff.in_pict;
        end
        next_state.regional_odd = (unit_type == TY_RI) ? !eff.regional_odd : 1'b0;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/grapheme_cluster_break_detector_top.sv
// a request is registered in the input stage, and its break bit then in the result register once that is free
// throughput: one request per cycle while results are taken, context held in a single register stage
// a stalled result register still lets the input register drain into it when taken
// async active-low reset clears valid flags and restores start-of-text context
`default_nettype none

`include "grapheme_cluster_break_detector_top_assert.svh"

module grapheme_cluster_break_detector_top
    import gcbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [3:0] unit_type,
    input  logic       start_of_text,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       break_before
);

    logic        stage_valid_reg;
    unit_t       stage_type_reg;
    logic        stage_sot_reg;
    logic        out_valid_reg;
    logic        out_brk_reg;
    gcbd_state_t state_reg;
    gcbd_state_t state_next;
    logic        brk_next;
    logic        advance;

    assign advance    = stage_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    gcbd_rules u_rules (
        .cur_state     (state_reg),
        .unit_type     (stage_type_reg),
        .start_of_text (stage_sot_reg),
        .brk           (brk_next),
        .next_state    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= STATE_RESET;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_type_reg <= unit_type;
            stage_sot_reg  <= start_of_text;
        end
        if (advance)
        begin
            out_brk_reg <= brk_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign break_before = out_brk_reg;

    `GCBD_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !stage_valid_reg, item_ready)
    `GCBD_ASSERT_NEXT(a_sot_breaks, clk, rst_n, advance && stage_sot_reg,
                      result_valid && break_before)
    `GCBD_ASSERT_NEXT(a_crlf_joined, clk, rst_n,
                      advance && !stage_sot_reg && !state_reg.first_pending &&
                      state_reg.prev_type == TY_CR && stage_type_reg == TY_LF,
                      !break_before)
    `GCBD_ASSERT_NEXT(a_first_cleared, clk, rst_n, advance, !state_reg.first_pending)

endmodule

`default_nettype wire

FILE: verif/grapheme_cluster_break_detector_top_tb.sv
// self-checking testbench for the grapheme cluster break detector, predicting every break bit
`timescale 1ns / 1ps

module grapheme_cluster_break_detector_top_tb;

    import gcbd_pkg::*;

    localparam unit_t TY_UNUSED      = 4'd15;
    localparam int    WATCHDOG_LIMIT = 200;
    localparam int    DRAIN_CYCLES   = 8;
    localparam int    THROTTLED_END  = 375;
    localparam int    RUN_END        = 425;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [3:0] unit_type;
    logic       start_of_text;
    logic       result_valid;
    logic       result_ready;
    logic       break_before;

    logic        idle_en = 1'b1;
    int          sent_count = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    logic        expected_breaks[$];
    gcbd_state_t cluster_ctx = STATE_RESET;

    grapheme_cluster_break_detector_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .unit_type     (unit_type),
        .start_of_text (start_of_text),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .break_before  (break_before)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic is_control_class(input unit_t ty);
        return ty == TY_CR || ty == TY_LF || ty == TY_CONTROL;
    endfunction

    function automatic logic predict_break(input unit_t ty, input logic sot);
        logic  brk;
        unit_t lhs;
        if (sot)
            cluster_ctx = STATE_RESET;
        lhs = cluster_ctx.prev_type;
        if (cluster_ctx.first_pending)
            brk = 1'b1;
        else if (lhs == TY_CR && ty == TY_LF)
            brk = 1'b0;
        else if (is_control_class(lhs) || is_control_class(ty))
            brk = 1'b1;
        else if (lhs == TY_L && (ty == TY_L || ty == TY_V || ty == TY_LV || ty == TY_LVT))
            brk = 1'b0;
        else if ((lhs == TY_LV || lhs == TY_V) && (ty == TY_V || ty == TY_T))
            brk = 1'b0;
        else if ((lhs == TY_LVT || lhs == TY_T) && ty == TY_T)
            brk = 1'b0;
        else if (ty == TY_EXTEND || ty == TY_ZWJ || ty == TY_SPACING || lhs == TY_PREPEND)
            brk = 1'b0;
        else if (cluster_ctx.in_pict && lhs == TY_ZWJ && ty == TY_EXTPICT)
            brk = 1'b0;
        else if (lhs == TY_RI && ty == TY_RI && cluster_ctx.regional_odd)
            brk = 1'b0;
        else
            brk = 1'b1;
        cluster_ctx.first_pending = 1'b0;
        if (ty == TY_EXTPICT)
            cluster_ctx.in_pict = 1'b1;
        else if (ty != TY_EXTEND && ty != TY_ZWJ)
            cluster_ctx.in_pict = 1'b0;
        cluster_ctx.regional_odd = (ty == TY_RI) ? ~cluster_ctx.regional_odd : 1'b0;
        cluster_ctx.prev_type = ty;
        return brk;
    endfunction

    function automatic logic sot_bit();
        return $urandom_range(0, 15) == 0;
    endfunction

    task automatic send_unit(input unit_t ty, input logic sot);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid    <= 1'b1;
        unit_type     <= ty;
        start_of_text <= sot;
        do
            @(posedge clk);
        while (!item_ready);
        sent_count++;
    endtask

    // request and result monitor, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                expected_breaks.push_back(predict_break(unit_type, start_of_text));
            if (result_valid && result_ready)
            begin
                if (expected_breaks.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none actual %0b",
                             $time, break_before);
                end
                else if (expected_breaks[0] !== break_before)
                begin
                    mismatch_count++;
                    $display("%0t: break_before mismatch, expected %0b actual %0b",
                             $time, expected_breaks[0], break_before);
                    void'(expected_breaks.pop_front());
                end
                else
                    void'(expected_breaks.pop_front());
            end
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("grapheme_cluster_break_detector_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_en && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    task automatic test_directed_rules();
        send_unit(TY_OTHER, 1'b1);
        send_unit(TY_CR, 1'b0);
        send_unit(TY_LF, 1'b0);
        send_unit(TY_CONTROL, 1'b0);
        send_unit(TY_L, 1'b0);
        send_unit(TY_L, 1'b0);
        send_unit(TY_V, 1'b0);
        send_unit(TY_T, 1'b0);
        send_unit(TY_LVT, 1'b0);
        send_unit(TY_T, 1'b0);
        send_unit(TY_LV, 1'b0);
        send_unit(TY_V, 1'b0);
        send_unit(TY_PREPEND, 1'b0);
        send_unit(TY_OTHER, 1'b0);
        send_unit(TY_EXTEND, 1'b0);
        send_unit(TY_SPACING, 1'b0);
        send_unit(TY_EXTPICT, 1'b0);
        send_unit(TY_EXTEND, 1'b0);
        send_unit(TY_ZWJ, 1'b0);
        send_unit(TY_EXTPICT, 1'b0);
        send_unit(TY_RI, 1'b0);
        send_unit(TY_RI, 1'b0);
        send_unit(TY_RI, 1'b0);
    endtask

    task automatic test_special_cases();
        send_unit(TY_UNUSED, 1'b0);
        send_unit(TY_EXTEND, 1'b0);
        send_unit(TY_RI, 1'b1);
        send_unit(TY_RI, 1'b0);
        send_unit(TY_UNUSED, 1'b1);
    endtask

    task automatic test_random_stream(input int stop_count);
        int n;
        while (sent_count < stop_count)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    send_unit(TY_EXTPICT, sot_bit());
                    repeat ($urandom_range(0, 2)) send_unit(TY_EXTEND, sot_bit());
                    send_unit(TY_ZWJ, sot_bit());
                    send_unit(TY_EXTPICT, sot_bit());
                end
                1:
                    repeat ($urandom_range(1, 5)) send_unit(TY_RI, sot_bit());
                2:
                begin
                    repeat ($urandom_range(0, 2)) send_unit(TY_L, sot_bit());
                    n = $urandom_range(0, 2);
                    if (n == 0)
                        send_unit(TY_V, sot_bit());
                    else if (n == 1)
                        send_unit(TY_LV, sot_bit());
                    else
                        send_unit(TY_LVT, sot_bit());
                    if (n != 2 && $urandom_range(0, 1) == 0)
                        send_unit(TY_V, sot_bit());
                    repeat ($urandom_range(0, 2)) send_unit(TY_T, sot_bit());
                end
                3:
                begin
                    send_unit(TY_CR, sot_bit());
                    if ($urandom_range(0, 3) != 0)
                        send_unit(TY_LF, sot_bit());
                end
                4:
                begin
                    send_unit(TY_PREPEND, sot_bit());
                    send_unit(unit_t'($urandom_range(0, 15)), sot_bit());
                    send_unit($urandom_range(0, 1) ? TY_SPACING : TY_EXTEND, sot_bit());
                end
                default:
                    repeat ($urandom_range(1, 4))
                        send_unit(unit_t'($urandom_range(0, 15)), sot_bit());
            endcase
        end
    endtask

    task automatic test_back_to_back(input int stop_count);
        idle_en = 1'b0;
        test_random_stream(stop_count);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        unit_type     = TY_OTHER;
        start_of_text = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_rules();
        test_special_cases();
        test_random_stream(THROTTLED_END);
        test_back_to_back(RUN_END);
        item_valid <= 1'b0;
        while (expected_breaks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_breaks.size() == 0)
            $display("grapheme_cluster_break_detector_top test passed");
        else
            $display("grapheme_cluster_break_detector_top test failed");
        $finish;
    end

endmodule
